// ===== hdl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg: digitizer event packet parser package
// Word and result types, result kind codes, length limits and the helper
// that multiplies a time byte by the coarse clock period.
// ----------------------------------------------------------------------------
package dpp_pkg;

  // largest accepted packet length in words
  localparam int MAX_PACKET_WORDS = 16384;

  localparam logic [14:0] LEN_MIN = 15'd32;
  localparam logic [14:0] LEN_MAX = 15'(MAX_PACKET_WORDS);
  localparam logic [14:0] LEN_SAT = 15'h7FFF;

  // header word positions with special handling
  localparam logic [14:0] IDX_LEN_CHECK  = 15'd3;
  localparam logic [14:0] IDX_HDR_LAST   = 15'd31;
  localparam logic [14:0] IDX_FIRST_DATA = 15'd32;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_SAMPLES = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] word;
    logic        buffer_end;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [14:0] length_words;
    logic [15:0] run_id;
    logic [3:0]  trig_type;
    logic [31:0] trig_count;
    logic [33:0] trigger_time_ns;
    logic [7:0]  module_id;
    logic [31:0] local_trig_count;
    logic [31:0] trig_mask;
    logic [57:0] local_time_ns;
    logic [63:0] sample_group;
  } out_res_t;

  // byte times 1000 as 1024 - 16 - 8
  function automatic logic [17:0] times_1000(input logic [7:0] b);
    logic [17:0] p;
    p = {b, 10'd0} - {6'd0, b, 4'd0} - {7'd0, b, 3'd0};
    return p;
  endfunction

endpackage

// ===== hdl/digitizer_event_packet_parser_top.sv =====
// ----------------------------------------------------------------------------
// digitizer_event_packet_parser_top: digitizer event packet parser
// Parses header and sample words of four-channel digitizer event packets.
// ----------------------------------------------------------------------------
// The parser takes one word per cycle, every cycle, for as long as results are
// taken; a word passes an input register, one parse stage and a result
// register, so its result is registered when the parse stage steps on it, which
// waits while the result register is full and not taken. The header result
// follows header word 31, sample groups follow every second data word, and a
// bad length is reported at word 3, after which words are dropped through the
// next buffer end word unless word 3 ends the buffer. The rate is set by the
// single parse stage, which updates the packet state once per word.
module digitizer_event_packet_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dpp_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dpp_pkg::out_res_t  out_data_o
);
  import dpp_pkg::*;

  logic      s1_vld_q;
  in_word_t  s1_word_q;
  logic      out_vld_q;
  out_res_t  out_res_q;
  logic      out_free;
  logic      step;
  out_res_t  res;
  logic      res_vld;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = s1_vld_q && out_free;
  assign in_ready_o = !s1_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_vld_q <= 1'b1;
    end else if (step) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_data_i;
    end
  end

  // parse stage
  dpp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .word_i    (s1_word_q),
    .res_o     (res),
    .res_vld_o (res_vld)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_res_q;

  // a stalled input means both stages hold words and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled while a stage was free");

  // a rejection always closes the packet
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_REJECT) |-> out_data_o.last)
    else $error("rejection without last");

  // sample groups only come from packets with an accepted length
  a_samples_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_SAMPLES) |->
      (out_data_o.length_words >= LEN_MIN && out_data_o.length_words <= LEN_MAX))
    else $error("sample group from a packet with a bad length");

endmodule

// ===== hdl/dpp_parser.sv =====
// ----------------------------------------------------------------------------
// dpp_parser: packet parse stage
// Holds the parse state, collects header bytes, builds sample groups and
// forms one result per step where the packet position calls for it.
// ----------------------------------------------------------------------------
module dpp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dpp_pkg::in_word_t  word_i,
  output dpp_pkg::out_res_t  res_o,
  output logic               res_vld_o
);
  import dpp_pkg::*;

  logic [14:0] idx_q, idx_d;
  logic        disc_q, disc_d;
  logic [14:0] len_q, len_d;
  logic [15:0] run_q, run_d;
  logic [3:0]  type_q, type_d;
  logic [31:0] trig_num_q, trig_num_d;
  logic [33:0] trig_time_q, trig_time_d;
  logic [7:0]  module_q, module_d;
  logic [31:0] local_num_q, local_num_d;
  logic [31:0] pattern_q, pattern_d;
  logic [57:0] local_time_q, local_time_d;
  logic [31:0] low_word_q, low_word_d;

  logic [7:0]  b;
  logic [17:0] b_k;
  logic [1:0]  pos4;
  logic [2:0]  pos8;
  logic [33:0] trig_add;
  logic [57:0] local_add;
  logic        last_pair;
  out_res_t    res;
  logic        res_vld;

  assign b    = word_i.word[7:0];
  assign b_k  = times_1000(b);

  // scaled coarse byte at its place in the trigger time
  always_comb begin
    case (idx_q[1:0])
      2'd0:    trig_add = {16'd0, b_k};
      2'd1:    trig_add = {8'd0, b_k, 8'd0};
      2'd2:    trig_add = {b_k, 16'd0};
      default: trig_add = '0;
    endcase
  end

  // scaled coarse byte at its place in the local time
  assign pos8 = idx_q[2:0] - 3'd2;
  always_comb begin
    case (pos8)
      3'd0:    local_add = {40'd0, b_k};
      3'd1:    local_add = {32'd0, b_k, 8'd0};
      3'd2:    local_add = {24'd0, b_k, 16'd0};
      3'd3:    local_add = {16'd0, b_k, 24'd0};
      3'd4:    local_add = {8'd0, b_k, 32'd0};
      3'd5:    local_add = {b_k, 40'd0};
      default: local_add = '0;
    endcase
  end

  assign last_pair = ({1'b0, idx_q} + 16'd2) >= {1'b0, len_q};

  // parse one word
  always_comb begin
    idx_d        = idx_q;
    disc_d       = disc_q;
    len_d        = len_q;
    run_d        = run_q;
    type_d       = type_q;
    trig_num_d   = trig_num_q;
    trig_time_d  = trig_time_q;
    module_d     = module_q;
    local_num_d  = local_num_q;
    pattern_d    = pattern_q;
    local_time_d = local_time_q;
    low_word_d   = low_word_q;
    pos4         = 2'd0;
    res          = '0;
    res_vld      = 1'b0;

    if (disc_q) begin
      // drop words until the buffer ends
      if (word_i.buffer_end) begin
        disc_d = 1'b0;
        idx_d  = '0;
      end
    end else begin
      // header byte collection
      case (idx_q) inside
        15'd0: len_d = {7'd0, b};
        15'd1: begin
          len_d = {b[6:0], len_q[7:0]};
          if (b[7]) len_d = LEN_SAT;
        end
        15'd2, 15'd3: begin
          if (b != 8'd0) len_d = LEN_SAT;
        end
        15'd4: run_d[7:0] = b;
        15'd5: run_d[15:8] = b;
        15'd6: type_d = b[3:0];
        [15'd7:15'd10]: begin
          pos4 = idx_q[1:0] + 2'd1;
          trig_num_d[8*pos4 +: 8] = b;
        end
        15'd11: trig_time_d = {23'd0, b, 3'd0};
        [15'd12:15'd14]: trig_time_d = trig_time_q + trig_add;
        15'd15: module_d = b;
        [15'd17:15'd20]: begin
          pos4 = idx_q[1:0] - 2'd1;
          local_num_d[8*pos4 +: 8] = b;
        end
        [15'd21:15'd24]: begin
          pos4 = idx_q[1:0] - 2'd1;
          pattern_d[8*pos4 +: 8] = b;
        end
        15'd25: local_time_d = {47'd0, b, 3'd0};
        [15'd26:15'd31]: local_time_d = local_time_q + local_add;
        default: ;
      endcase

      // result forming
      if (idx_q == IDX_HDR_LAST) begin
        res.kind             = KIND_HEADER;
        res.last             = last_pair;
        res.length_words     = len_q;
        res.run_id           = run_q;
        res.trig_type        = type_q;
        res.trig_count       = trig_num_q;
        res.trigger_time_ns  = trig_time_q;
        res.module_id        = module_q;
        res.local_trig_count = local_num_q;
        res.trig_mask        = pattern_q;
        res.local_time_ns    = local_time_d;
        res_vld              = 1'b1;
      end else if (idx_q >= IDX_FIRST_DATA) begin
        if (!idx_q[0]) begin
          low_word_d = word_i.word;
        end else begin
          res.kind         = KIND_SAMPLES;
          res.last         = last_pair;
          res.length_words = len_q;
          for (int c = 0; c < 4; c++) begin
            res.sample_group[16*c +: 16] = {word_i.word[8*c +: 8], low_word_q[8*c +: 8]};
          end
          res_vld = 1'b1;
        end
      end

      // word position and length check
      if (idx_q == IDX_LEN_CHECK && (len_d < LEN_MIN || len_d > LEN_MAX)) begin
        res              = '0;
        res.kind         = KIND_REJECT;
        res.last         = 1'b1;
        res.length_words = len_d;
        res_vld          = 1'b1;
        idx_d            = '0;
        disc_d           = !word_i.buffer_end;
      end else if (idx_q >= IDX_LEN_CHECK &&
                   ({1'b0, idx_q} + 16'd1) >= {1'b0, len_d}) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 15'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      disc_q       <= 1'b0;
      len_q        <= '0;
      run_q        <= '0;
      type_q       <= '0;
      trig_num_q   <= '0;
      trig_time_q  <= '0;
      module_q     <= '0;
      local_num_q  <= '0;
      pattern_q    <= '0;
      local_time_q <= '0;
      low_word_q   <= '0;
    end else if (step_i) begin
      idx_q        <= idx_d;
      disc_q       <= disc_d;
      len_q        <= len_d;
      run_q        <= run_d;
      type_q       <= type_d;
      trig_num_q   <= trig_num_d;
      trig_time_q  <= trig_time_d;
      module_q     <= module_d;
      local_num_q  <= local_num_d;
      pattern_q    <= pattern_d;
      local_time_q <= local_time_d;
      low_word_q   <= low_word_d;
    end
  end

  assign res_o     = res;
  assign res_vld_o = res_vld;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: digitizer event packet parser testbench
// Streams event packets through the parser. A tracker rebuilds every header,
// sample group and rejection from the words the parser accepts, and checks
// each result in order, field by field. Stimulus covers directed corner
// packets, then mostly well-formed random packets mixed with bad lengths.
// The sender idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
  import dpp_pkg::*;

  localparam int FILL_RANDOM     = 0;
  localparam int FILL_ZERO       = 1;
  localparam int FILL_ONES       = 2;
  localparam int MODE_OPEN       = 0;
  localparam int MODE_COIN       = 1;
  localparam int MODE_SPARSE     = 2;
  localparam int RANDOM_WORDS    = 680;
  localparam int LONG_HEAD_WORDS = 48;
  localparam int DRAIN_CYCLES    = 20000;
  localparam int SETTLE          = 8;

  // predicts parser results from accepted words and checks them in order
  class parse_tracker;
    out_res_t    pending_q[$];
    int          errors = 0;
    int          words = 0;
    int          dropped = 0;
    int          headers = 0;
    int          groups = 0;
    int          rejects = 0;
    logic [14:0] word_idx = '0;
    logic [14:0] plen = '0;
    bit          dropping = 1'b0;
    logic [15:0] run = '0;
    logic [3:0]  ttype = '0;
    logic [31:0] trig_num = '0;
    logic [7:0]  fine_trig = '0;
    logic [23:0] coarse_trig = '0;
    logic [7:0]  module_id = '0;
    logic [31:0] local_num = '0;
    logic [31:0] pattern = '0;
    logic [7:0]  fine_local = '0;
    logic [47:0] coarse_local = '0;
    logic [31:0] low_word = '0;

    function void take_word(in_word_t w);
      logic [7:0]  b;
      int          i;
      out_res_t    r;
      logic [63:0] t;
      logic [63:0] g;
      b = w.word[7:0];
      i = word_idx;
      r = '0;
      words++;
      // after a rejection, words are dropped through the buffer end
      if (dropping) begin
        dropped++;
        if (w.buffer_end) begin
          dropping = 1'b0;
          word_idx = '0;
        end
        return;
      end
      // header byte capture
      if (i == 0) plen = {7'd0, b};
      else if (i == 1) plen = b[7] ? LEN_SAT : {b[6:0], plen[7:0]};
      else if (i <= 3) begin
        if (b != 8'd0) plen = LEN_SAT;
      end
      else if (i <= 5) run[8*(i-4) +: 8] = b;
      else if (i == 6) ttype = b[3:0];
      else if (i <= 10) trig_num[8*(i-7) +: 8] = b;
      else if (i == 11) fine_trig = b;
      else if (i <= 14) coarse_trig[8*(i-12) +: 8] = b;
      else if (i == 15) module_id = b;
      else if (i == 16) begin
        // spare header word
      end
      else if (i <= 20) local_num[8*(i-17) +: 8] = b;
      else if (i <= 24) pattern[8*(i-21) +: 8] = b;
      else if (i == 25) fine_local = b;
      else if (i <= 31) coarse_local[8*(i-26) +: 8] = b;

      // length check at the last length byte
      if (i == 3 && (plen < LEN_MIN || plen > LEN_MAX)) begin
        r.kind = KIND_REJECT;
        r.last = 1'b1;
        r.length_words = plen;
        pending_q = {pending_q, r};
        word_idx = '0;
        dropping = !w.buffer_end;
        return;
      end

      if (i == 31) begin
        r.kind = KIND_HEADER;
        r.last = (i + 2 >= plen);
        r.length_words = plen;
        r.run_id = run;
        r.trig_type = ttype;
        r.trig_count = trig_num;
        t = 64'(fine_trig) * 64'd8 + 64'(coarse_trig) * 64'd1000;
        r.trigger_time_ns = t[33:0];
        r.module_id = module_id;
        r.local_trig_count = local_num;
        r.trig_mask = pattern;
        t = 64'(fine_local) * 64'd8 + 64'(coarse_local) * 64'd1000;
        r.local_time_ns = t[57:0];
        pending_q = {pending_q, r};
      end else if (i >= 32) begin
        if (i % 2 == 0) low_word = w.word;
        else begin
          // low bytes from the first word, high bytes from the second
          for (int c = 0; c < 4; c++)
            g[16*c +: 16] = {w.word[8*c +: 8], low_word[8*c +: 8]};
          r.kind = KIND_SAMPLES;
          r.last = (i + 2 >= plen);
          r.length_words = plen;
          r.sample_group = g;
          pending_q = {pending_q, r};
        end
      end

      word_idx = (i >= 3 && i + 1 >= plen) ? 15'd0 : 15'(i + 1);
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void match_result(out_res_t got);
      out_res_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      compare("kind", e.kind, got.kind);
      compare("last", e.last, got.last);
      compare("length_words", e.length_words, got.length_words);
      compare("run_id", e.run_id, got.run_id);
      compare("trig_type", e.trig_type, got.trig_type);
      compare("trig_count", e.trig_count, got.trig_count);
      compare("trigger_time_ns", e.trigger_time_ns, got.trigger_time_ns);
      compare("module_id", e.module_id, got.module_id);
      compare("local_trig_count", e.local_trig_count, got.local_trig_count);
      compare("trig_mask", e.trig_mask, got.trig_mask);
      compare("local_time_ns", e.local_time_ns, got.local_time_ns);
      compare("sample_group", e.sample_group, got.sample_group);
      case (e.kind)
        KIND_HEADER:  headers++;
        KIND_SAMPLES: groups++;
        default:      rejects++;
      endcase
    endfunction

    function void report_leftover();
      if (pending_q.size() != 0) begin
        $error("%0d results never arrived", pending_q.size());
        errors += pending_q.size();
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_word_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  parse_tracker tracker;
  int           burst_left = 0;
  int           ready_mode = MODE_OPEN;
  int           mode_left = 0;

  digitizer_event_packet_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both handshakes, words first so a result never beats its word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_word(in_data);
      if (out_valid && out_ready) tracker.match_result(out_data);
    end
  end

  // receiver stalls, in a pattern picked at random: open, coin flip or sparse
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(MODE_SPARSE);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (ready_mode)
        MODE_OPEN: out_ready <= 1'b1;
        MODE_COIN: out_ready <= 1'($urandom_range(1));
        default:   out_ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // present one word and hold it until taken; bursts with gaps between
  task automatic send_word(input logic [31:0] w, input logic be);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= in_word_t'{word: w, buffer_end: be};
    do @(posedge clk); while (!in_ready);
  endtask

  // one packet: length bytes in byte 0 of words 0..3, the rest per fill
  task automatic send_packet(input logic [31:0] len_bytes, input int nwords,
                             input int fill, input logic be3);
    logic [31:0] w;
    logic        be;
    for (int k = 0; k < nwords; k++) begin
      case (fill)
        FILL_ZERO: w = '0;
        FILL_ONES: w = '1;
        default:   w = $urandom;
      endcase
      if (k < 4) w[7:0] = len_bytes[8*k +: 8];
      be = (k == 3) ? be3 : ($urandom_range(7) == 0);
      send_word(w, be);
    end
  endtask

  // junk after a rejection, closed by a buffer end word
  task automatic drop_until_end(input int n);
    repeat (n) send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
  endtask

  initial begin
    int          rnd_words;
    int          len;
    int          guard;
    logic [31:0] lb;
    logic        be3;
    tracker = new();
    rnd_words = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: shortest packets, odd lengths, field extremes
    send_packet(32'd32, 32, FILL_ZERO, 1'b0);
    send_packet(32'd32, 32, FILL_ONES, 1'b1);
    send_packet(32'd33, 33, FILL_RANDOM, 1'b0);
    send_packet(32'd34, 34, FILL_ONES, 1'b0);
    send_packet(32'd35, 35, FILL_ZERO, 1'b0);
    // directed: bad lengths, with and without buffer end on word 3
    send_packet(32'd0, 4, FILL_RANDOM, 1'b0);
    drop_until_end(3);
    send_packet(32'd31, 4, FILL_ONES, 1'b1);
    send_packet(32'd16385, 4, FILL_RANDOM, 1'b0);
    drop_until_end(0);
    send_packet(32'h0000_8020, 4, FILL_RANDOM, 1'b0);
    drop_until_end(2);
    send_packet(32'h0001_0020, 4, FILL_ZERO, 1'b1);
    send_packet(32'h0100_0020, 4, FILL_RANDOM, 1'b0);
    drop_until_end(1);
    send_packet(32'h0000_7FFF, 4, FILL_RANDOM, 1'b1);

    // random: mostly good packets, some rejected with junk after them
    while (rnd_words < RANDOM_WORDS) begin
      if ($urandom_range(99) < 78) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(32, 400) : $urandom_range(32, 72);
        send_packet(32'(len), len, FILL_RANDOM, 1'($urandom_range(1)));
        rnd_words += len;
      end else begin
        case ($urandom_range(3))
          0:       lb = $urandom_range(0, 31);
          1:       lb = $urandom_range(MAX_PACKET_WORDS + 1, 32767);
          2:       lb = {16'd0, 1'b1, 15'($urandom)};
          default: begin
            lb = $urandom;
            if (lb[31:16] == 16'd0) lb[16] = 1'b1;
          end
        endcase
        be3 = ($urandom_range(3) == 0);
        send_packet(lb, 4, FILL_RANDOM, be3);
        rnd_words += 4;
        if (!be3) drop_until_end($urandom_range(0, 8));
      end
    end

    // directed: longest accepted length, header and a few pairs, left open
    send_packet(32'(MAX_PACKET_WORDS), LONG_HEAD_WORDS, FILL_RANDOM, 1'b0);
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    guard = 0;
    while (tracker.pending_q.size() != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    tracker.report_leftover();

    $display("words in: %0d, of which %0d dropped after bad lengths",
             tracker.words, tracker.dropped);
    $display("results checked: %0d headers, %0d sample groups, %0d rejections",
             tracker.headers, tracker.groups, tracker.rejects);
    if (tracker.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
